// ===== src/pwlt_pkg.sv =====
// Shared types and constants of the pulse-width link transceiver.
package pwlt_pkg;

	localparam int CMD_W = 3;
	localparam int DATA_W = 8;
	localparam int STORE_DEPTH = 8;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	localparam int FRAME_BYTES = 8;
	localparam int RX_FRAME_BYTES = 8;
	localparam int TX_POS_W = $clog2(FRAME_BYTES + 1);
	localparam int RX_POS_W = $clog2(RX_FRAME_BYTES + 1);
	localparam logic [TX_POS_W-1:0] FRAME_END = TX_POS_W'(FRAME_BYTES);
	localparam logic [RX_POS_W-1:0] RX_END = RX_POS_W'(RX_FRAME_BYTES);

	localparam int TICK_W = 5;
	localparam logic [TICK_W-1:0] HDR_LEN = TICK_W'(20 + 1);
	localparam logic [TICK_W-1:0] ONE_LEN = TICK_W'(15);
	localparam logic [TICK_W-1:0] ZERO_LEN = TICK_W'(10);
	localparam logic [TICK_W-1:0] TRAIL_LEN = TICK_W'(10);
	localparam logic [TICK_W-1:0] LOW_LEN = TICK_W'(5);
	localparam logic [TICK_W-1:0] HDR_LOW_LEN = TICK_W'(6);

	localparam int PERIOD_W = 8;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(255);
	localparam logic [PERIOD_W-1:0] HDR_MIN = PERIOD_W'(17);
	localparam logic [PERIOD_W-1:0] HDR_MAX = PERIOD_W'(23);
	localparam logic [PERIOD_W-1:0] ONE_MIN = PERIOD_W'(13);
	localparam logic [PERIOD_W-1:0] ONE_MAX = PERIOD_W'(17);
	localparam logic [PERIOD_W-1:0] ZERO_MIN = PERIOD_W'(8);
	localparam logic [PERIOD_W-1:0] ZERO_MAX = PERIOD_W'(12);

	localparam logic [DATA_W-1:0] FIRST_BIT = DATA_W'(8'h01);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_WRITE_TX   = 3'd1,
		CMD_START      = 3'd2,
		CMD_READ_RX    = 3'd3,
		CMD_CLEAR_DONE = 3'd4
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic              line_in;
		logic [ADDR_W-1:0] index;
		logic [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic tx_busy;
	} tx_stat_t;

	typedef struct packed {
		logic              rx_done;
		logic [DATA_W-1:0] rx_data;
	} rx_stat_t;

endpackage

// ===== src/pulse_width_link_transceiver.sv =====
// Top level of the pulse-width link transceiver: handshake, item stage and result register.
// An item fills the item stage and the store read; its execution loads the result register.
// Throughput: one item per clock while out_ready holds; the limit is the store read,
// overlapped with the update of the previous item through write forwarding.
// Reset: arst_n clears all control state at once; the stores read as zero until written.
module pulse_width_link_transceiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pwlt_pkg::CMD_W-1:0]    command,
	input  logic                          line_in,
	input  logic [pwlt_pkg::ADDR_W-1:0]   index,
	input  logic [pwlt_pkg::DATA_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_out,
	output logic                          tx_busy,
	output logic                          rx_done,
	output logic [pwlt_pkg::DATA_W-1:0]   rx_data
);

	import pwlt_pkg::*;

	item_t    in_item;
	item_t    item_s1;
	logic     s1_valid_q;
	logic     out_valid_q;
	logic     exec;
	logic     issue;
	logic     tx_busy_cur;
	tx_stat_t tx_next;
	rx_stat_t rx_next;

	logic              line_out_q;
	logic              tx_busy_q;
	logic              rx_done_q;
	logic [DATA_W-1:0] rx_data_q;

	assign in_item = '{command: cmd_t'(command), line_in: line_in, index: index, value: value};
	assign exec = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || exec;
	assign issue = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (exec) begin
				s1_valid_q <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			item_s1 <= in_item;
		end
		if (exec) begin
			line_out_q <= tx_next.line_level;
			tx_busy_q <= tx_next.tx_busy;
			rx_done_q <= rx_next.rx_done;
			rx_data_q <= rx_next.rx_data;
		end
	end

	pwlt_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.exec      (exec),
		.item_s1   (item_s1),
		.busy      (tx_busy_cur),
		.stat_next (tx_next)
	);

	pwlt_rx u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.in_item   (in_item),
		.exec      (exec),
		.item_s1   (item_s1),
		.tx_busy   (tx_busy_cur),
		.stat_next (rx_next)
	);

	assign out_valid = out_valid_q;
	assign line_out = line_out_q;
	assign tx_busy = tx_busy_q;
	assign rx_done = rx_done_q;
	assign rx_data = rx_data_q;

	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_busy |-> line_out)
		else $error("Transmit line is low in a result that shows the transmitter idle.");

endmodule

// ===== src/pwlt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pwlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pwlt_tx.sv =====
// Transmitter: frame sequencer around the transmit byte store.
module pwlt_tx (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               issue,
	input  logic               exec,
	input  pwlt_pkg::item_t    item_s1,
	output logic               busy,
	output pwlt_pkg::tx_stat_t stat_next
);

	import pwlt_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_DATA    = 2'd1,
		PH_TRAILER = 2'd2
	} phase_t;

	phase_t              phase_q, phase_d;
	logic                en_q, en_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [TX_POS_W-1:0] pos_q, pos_d;
	logic [DATA_W-1:0]   mask_q, mask_d;
	logic                line_q, line_d;

	logic [STORE_DEPTH-1:0] valid_q;
	logic                   fwd_s1;
	logic                   rd_valid_s1;
	logic [DATA_W-1:0]      fwd_data_s1;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] tx_byte;

	assign tx_byte = fwd_s1 ? fwd_data_s1 : (rd_valid_s1 ? rdata : '0);
	assign raddr = ADDR_W'(pos_d);

	always_comb begin
		logic [TICK_W-1:0]   tc;
		logic [TICK_W-1:0]   low_len;
		logic [TICK_W-1:0]   sym_len;
		logic [DATA_W-1:0]   msk;
		logic [TX_POS_W-1:0] pos;

		en_d = en_q;
		phase_d = phase_q;
		tick_d = tick_q;
		pos_d = pos_q;
		mask_d = mask_q;
		line_d = line_q;
		we = 1'b0;
		waddr = item_s1.index;
		wdata = item_s1.value;
		tc = tick_q + 1'b1;
		low_len = LOW_LEN;
		sym_len = ZERO_LEN;
		msk = mask_q;
		pos = pos_q;

		if (exec) begin
			unique case (item_s1.command)
				CMD_TICK: begin
					if (en_q) begin
						unique case (phase_q)
							PH_DATA: begin
								sym_len = (|(tx_byte & mask_q)) ? ONE_LEN : ZERO_LEN;
								if (tc >= sym_len) begin
									tc = '0;
									msk = mask_q << 1;
								end
								if (msk == '0) begin
									msk = FIRST_BIT;
									pos = pos_q + 1'b1;
									if (pos >= FRAME_END) begin
										tc = '0;
										pos = '0;
										phase_d = PH_TRAILER;
									end
								end
								mask_d = msk;
								pos_d = pos;
							end
							PH_HEADER: begin
								low_len = HDR_LOW_LEN;
								if (tc >= HDR_LEN) begin
									tc = '0;
									mask_d = FIRST_BIT;
									phase_d = PH_DATA;
								end
							end
							default: begin
								if (tc >= TRAIL_LEN) begin
									phase_d = PH_HEADER;
									en_d = 1'b0;
								end
							end
						endcase
						tick_d = tc;
						line_d = (tc >= low_len);
					end
				end
				CMD_WRITE_TX: begin
					we = 1'b1;
				end
				CMD_START: begin
					en_d = 1'b1;
					phase_d = PH_HEADER;
					tick_d = '0;
					pos_d = '0;
					line_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = en_q;
	assign stat_next = '{line_level: line_d, tx_busy: en_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			phase_q <= PH_HEADER;
			tick_q <= '0;
			pos_q <= '0;
			mask_q <= '0;
			line_q <= 1'b1;
			valid_q <= '0;
			fwd_s1 <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			en_q <= en_d;
			phase_q <= phase_d;
			tick_q <= tick_d;
			pos_q <= pos_d;
			mask_q <= mask_d;
			line_q <= line_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (issue) begin
				fwd_s1 <= we && (waddr == raddr);
				rd_valid_s1 <= valid_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			fwd_data_s1 <= wdata;
		end
	end

	pwlt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	a_data_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		en_q && phase_q == PH_DATA |-> $onehot(mask_q))
		else $error("Transmit bit mask is not one-hot during the data phase.");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < FRAME_END)
		else $error("Transmit byte position ran past the frame length.");

endmodule

// ===== src/pwlt_rx.sv =====
// Receiver: period timer and symbol decoder around the receive byte store.
module pwlt_rx (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               issue,
	input  pwlt_pkg::item_t    in_item,
	input  logic               exec,
	input  pwlt_pkg::item_t    item_s1,
	input  logic               tx_busy,
	output pwlt_pkg::rx_stat_t stat_next
);

	import pwlt_pkg::*;

	logic [PERIOD_W-1:0] pc_q, pc_d;
	logic                prev_q, prev_d;
	logic                active_q, active_d;
	logic [DATA_W-1:0]   mask_q, mask_d;
	logic [RX_POS_W-1:0] pos_q, pos_d;
	logic                done_q, done_d;

	logic [STORE_DEPTH-1:0] valid_q;
	logic                   fwd_s1;
	logic                   rd_valid_s1;
	logic [DATA_W-1:0]      fwd_data_s1;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] rx_byte;

	assign rx_byte = fwd_s1 ? fwd_data_s1 : (rd_valid_s1 ? rdata : '0);
	assign raddr = (in_item.command == CMD_READ_RX) ? in_item.index : ADDR_W'(pos_d);

	always_comb begin
		logic [PERIOD_W-1:0] pc;
		logic [DATA_W-1:0]   msk;
		logic [RX_POS_W-1:0] pos;
		logic                adv;

		pc_d = pc_q;
		prev_d = prev_q;
		active_d = active_q;
		mask_d = mask_q;
		pos_d = pos_q;
		done_d = done_q;
		we = 1'b0;
		waddr = ADDR_W'(pos_q);
		wdata = rx_byte;
		pc = pc_q;
		msk = mask_q;
		pos = pos_q;
		adv = 1'b0;

		if (exec) begin
			unique case (item_s1.command)
				CMD_TICK: begin
					if (!tx_busy) begin
						pc = (pc_q != PERIOD_MAX) ? pc_q + 1'b1 : pc_q;
						if (!item_s1.line_in) begin
							if (prev_q) begin
								prev_d = 1'b0;
								priority if (pc >= HDR_MIN && pc <= HDR_MAX) begin
									active_d = 1'b1;
									mask_d = FIRST_BIT;
									pos_d = '0;
								end else if (!active_q) begin
								end else if (pos_q >= RX_END) begin
									active_d = 1'b0;
								end else if (pc >= ONE_MIN && pc <= ONE_MAX) begin
									we = 1'b1;
									wdata = rx_byte | mask_q;
									adv = 1'b1;
								end else if (pc >= ZERO_MIN && pc <= ZERO_MAX) begin
									we = 1'b1;
									wdata = rx_byte & ~mask_q;
									adv = 1'b1;
								end else begin
									active_d = 1'b0;
								end
								if (adv) begin
									msk = mask_q << 1;
									if (msk == '0) begin
										msk = FIRST_BIT;
										pos = pos_q + 1'b1;
										if (pos >= RX_END) begin
											done_d = 1'b1;
											active_d = 1'b0;
										end
									end
									mask_d = msk;
									pos_d = pos;
								end
								pc = '0;
							end
						end else begin
							prev_d = 1'b1;
						end
						pc_d = pc;
					end
				end
				CMD_CLEAR_DONE: begin
					done_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign stat_next = '{
		rx_done: done_d,
		rx_data: (item_s1.command == CMD_READ_RX) ? rx_byte : '0
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			prev_q <= 1'b0;
			active_q <= 1'b0;
			mask_q <= '0;
			pos_q <= '0;
			done_q <= 1'b0;
			valid_q <= '0;
			fwd_s1 <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			pc_q <= pc_d;
			prev_q <= prev_d;
			active_q <= active_d;
			mask_q <= mask_d;
			pos_q <= pos_d;
			done_q <= done_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (issue) begin
				fwd_s1 <= we && (waddr == raddr);
				rd_valid_s1 <= valid_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			fwd_data_s1 <= wdata;
		end
	end

	pwlt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	a_active_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> $onehot(mask_q))
		else $error("Receive bit mask is not one-hot while a frame is active.");

	a_active_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> pos_q < RX_END)
		else $error("Receive byte position reached the frame length while active.");

endmodule

// ===== dv/pulse_width_link_transceiver_tb.sv =====
// Self-checking testbench of the pulse-width link transceiver: directed table, then random frames and noise.
module pulse_width_link_transceiver_tb;
	import pwlt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;

	localparam int BYTES_PER_FRAME = 8;
	localparam int HEADER_TICKS = 21;
	localparam int ONE_TICKS = 15;
	localparam int ZERO_TICKS = 10;
	localparam int TRAILER_TICKS = 10;
	localparam int LOW_TICKS = 5;
	localparam int HEADER_LOW_TICKS = 6;
	localparam int HEADER_PERIOD_MIN = 17;
	localparam int HEADER_PERIOD_MAX = 23;
	localparam int ONE_PERIOD_MIN = 13;
	localparam int ONE_PERIOD_MAX = 17;
	localparam int ZERO_PERIOD_MIN = 8;
	localparam int ZERO_PERIOD_MAX = 12;
	localparam int PERIOD_CEILING = 255;

	localparam int ITEM_TARGET = 1350;
	localparam int SEND_QUIET_FROM = 500;
	localparam int SEND_QUIET_TO = 900;
	localparam int TAKE_QUIET_FROM = 1000;
	localparam int TAKE_QUIET_TO = 1400;
	localparam int HOLD_AT_RESULT = 150;
	localparam int HOLD_CYCLES = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 400;
	localparam int SCRIPT_ROWS = 20;

	typedef enum logic [1:0] {
		STAGE_HEADER,
		STAGE_DATA,
		STAGE_TRAILER
	} tx_stage_t;

	typedef struct packed {
		logic              line_out;
		logic              tx_busy;
		logic              rx_done;
		logic [DATA_W-1:0] rx_data;
	} link_status_t;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic              line;
		logic [ADDR_W-1:0] idx;
		logic [DATA_W-1:0] val;
		bit                typed;
		link_status_t      status;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CMD_W-1:0]    command;
	logic                line_in;
	logic [ADDR_W-1:0]   index;
	logic [DATA_W-1:0]   value;
	logic                out_valid;
	logic                out_ready;
	logic                line_out;
	logic                tx_busy;
	logic                rx_done;
	logic [DATA_W-1:0]   rx_data;

	// Link state as the block should hold it.
	logic                tx_on;
	tx_stage_t           tx_stage;
	logic [4:0]          tick_cnt;
	logic [7:0]          tx_pos;
	logic [7:0]          tx_mask;
	logic [DATA_W-1:0]   tx_bytes [STORE_DEPTH];
	logic                drive_level;
	logic [7:0]          period_cnt;
	logic                last_line;
	logic                frame_open;
	logic [7:0]          rx_mask;
	logic [7:0]          rx_pos;
	logic [DATA_W-1:0]   rx_bytes [STORE_DEPTH];
	logic                frame_done;

	link_status_t        expected_status [$];
	link_status_t        wanted;
	link_status_t        seen;
	int                  item_count;
	int                  result_count;
	int                  fail_count;

	script_row_t opening_rows [SCRIPT_ROWS] = '{
		'{CMD_READ_RX, 1'b0, 3'd0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_READ_RX, 1'b1, 3'd7, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_SPARE_LAST, 1'b1, 3'd7, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_SPARE_FIRST, 1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{CMD_SPARE_MID, 1'b1, 3'd2, 8'h55, 1'b0, '0},
		'{CMD_WRITE_TX, 1'b0, 3'd0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_WRITE_TX, 1'b1, 3'd7, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_WRITE_TX, 1'b0, 3'd3, 8'hA5, 1'b0, '0},
		'{CMD_CLEAR_DONE, 1'b0, 3'd0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_TICK, 1'b1, 3'd0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_TICK, 1'b0, 3'd0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{CMD_TICK, 1'b1, 3'd5, 8'h00, 1'b0, '0},
		'{CMD_START, 1'b0, 3'd0, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
		'{CMD_TICK, 1'b1, 3'd0, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
		'{CMD_TICK, 1'b0, 3'd4, 8'h00, 1'b0, '0},
		'{CMD_START, 1'b1, 3'd0, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
		'{CMD_READ_RX, 1'b0, 3'd3, 8'h00, 1'b0, '0},
		'{CMD_WRITE_TX, 1'b0, 3'd1, 8'h5A, 1'b0, '0},
		'{CMD_TICK, 1'b1, 3'd6, 8'hC3, 1'b0, '0},
		'{CMD_CLEAR_DONE, 1'b1, 3'd5, 8'h00, 1'b0, '0}
	};

	pulse_width_link_transceiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.line_in   (line_in),
		.index     (index),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.line_out  (line_out),
		.tx_busy   (tx_busy),
		.rx_done   (rx_done),
		.rx_data   (rx_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_link_state();
		tx_on = 1'b0;
		tx_stage = STAGE_HEADER;
		tick_cnt = '0;
		tx_pos = '0;
		tx_mask = '0;
		drive_level = 1'b1;
		period_cnt = '0;
		last_line = 1'b0;
		frame_open = 1'b0;
		rx_mask = '0;
		rx_pos = '0;
		frame_done = 1'b0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			tx_bytes[i] = '0;
			rx_bytes[i] = '0;
		end
	endfunction

	function automatic void advance_transmitter();
		int low_len;
		int sym_len;
		low_len = LOW_TICKS;
		tick_cnt = tick_cnt + 5'd1;
		case (tx_stage)
		STAGE_DATA: begin
			sym_len = ((tx_bytes[tx_pos[2:0]] & tx_mask) != '0) ? ONE_TICKS : ZERO_TICKS;
			if (tick_cnt >= sym_len) begin
				tick_cnt = '0;
				tx_mask = tx_mask << 1;
			end
			if (tx_mask == '0) begin
				tx_mask = 8'h01;
				tx_pos = tx_pos + 8'd1;
				if (tx_pos >= BYTES_PER_FRAME) begin
					tick_cnt = '0;
					tx_pos = '0;
					tx_stage = STAGE_TRAILER;
				end
			end
		end
		STAGE_HEADER: begin
			low_len = HEADER_LOW_TICKS;
			if (tick_cnt >= HEADER_TICKS) begin
				tick_cnt = '0;
				tx_mask = 8'h01;
				tx_stage = STAGE_DATA;
			end
		end
		default: begin
			if (tick_cnt >= TRAILER_TICKS) begin
				tx_stage = STAGE_HEADER;
				tx_on = 1'b0;
			end
		end
		endcase
		drive_level = (tick_cnt < low_len) ? 1'b0 : 1'b1;
	endfunction

	function automatic void decode_period();
		int p;
		p = int'(period_cnt);
		if (p >= HEADER_PERIOD_MIN && p <= HEADER_PERIOD_MAX) begin
			frame_open = 1'b1;
			rx_mask = 8'h01;
			rx_pos = '0;
			return;
		end
		if (!frame_open)
			return;
		if (rx_pos >= BYTES_PER_FRAME) begin
			frame_open = 1'b0;
			return;
		end
		if (p >= ONE_PERIOD_MIN && p <= ONE_PERIOD_MAX) begin
			rx_bytes[rx_pos[2:0]] = rx_bytes[rx_pos[2:0]] | rx_mask;
		end else if (p >= ZERO_PERIOD_MIN && p <= ZERO_PERIOD_MAX) begin
			rx_bytes[rx_pos[2:0]] = rx_bytes[rx_pos[2:0]] & ~rx_mask;
		end else begin
			frame_open = 1'b0;
			return;
		end
		rx_mask = rx_mask << 1;
		if (rx_mask == '0) begin
			rx_mask = 8'h01;
			rx_pos = rx_pos + 8'd1;
			if (rx_pos >= BYTES_PER_FRAME) begin
				frame_done = 1'b1;
				frame_open = 1'b0;
			end
		end
	endfunction

	function automatic void advance_receiver(logic ln);
		if (period_cnt < PERIOD_CEILING)
			period_cnt = period_cnt + 8'd1;
		if (!ln) begin
			if (last_line) begin
				last_line = 1'b0;
				decode_period();
				period_cnt = '0;
			end
		end else begin
			last_line = 1'b1;
		end
	endfunction

	function automatic link_status_t predict_status(logic [CMD_W-1:0] cmd, logic ln,
			logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
		link_status_t st;
		st.rx_data = '0;
		case (cmd)
		CMD_TICK: begin
			if (tx_on)
				advance_transmitter();
			else
				advance_receiver(ln);
		end
		CMD_WRITE_TX: tx_bytes[idx] = val;
		CMD_START: begin
			tx_on = 1'b1;
			tx_stage = STAGE_HEADER;
			tick_cnt = '0;
			tx_pos = '0;
			drive_level = 1'b0;
		end
		CMD_READ_RX: st.rx_data = rx_bytes[idx];
		CMD_CLEAR_DONE: frame_done = 1'b0;
		default: ;
		endcase
		st.line_out = drive_level;
		st.tx_busy = tx_on;
		st.rx_done = frame_done;
		return st;
	endfunction

	function automatic void log_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, what);
	endfunction

	// Entered and left just after a falling edge, so the next drive lands there.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic ln, logic [ADDR_W-1:0] idx,
			logic [DATA_W-1:0] val, bit typed = 1'b0, link_status_t typed_status = '0);
		link_status_t st;
		int gap;
		bit quiet;
		quiet = item_count >= SEND_QUIET_FROM && item_count < SEND_QUIET_TO;
		if (!quiet && $urandom_range(99) < 6) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		line_in <= ln;
		index <= idx;
		value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		st = predict_status(cmd, ln, idx, val);
		expected_status.push_back(typed ? typed_status : st);
		item_count++;
		@(negedge clk);
	endtask

	task automatic send_side_command();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			send_item(CMD_WRITE_TX, 1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
				DATA_W'($urandom_range(255)));
		else if (r < 60)
			send_item(CMD_READ_RX, 1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
				DATA_W'($urandom_range(255)));
		else if (r < 75)
			send_item(CMD_CLEAR_DONE, 1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
				DATA_W'($urandom_range(255)));
		else
			send_item(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
				1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
				DATA_W'($urandom_range(255)));
	endtask

	task automatic send_tick(logic ln);
		if ($urandom_range(99) < 3)
			send_side_command();
		send_item(CMD_TICK, ln, ADDR_W'($urandom_range(7)), DATA_W'($urandom_range(255)));
	endtask

	task automatic send_symbol(int period);
		int low_len;
		low_len = ($urandom_range(3) != 0) ? LOW_TICKS : $urandom_range(1, period - 1);
		if (low_len >= period)
			low_len = period - 1;
		repeat (low_len) send_tick(1'b0);
		repeat (period - low_len) send_tick(1'b1);
	endtask

	task automatic finish_transmit();
		int r;
		while (tx_on) begin
			r = $urandom_range(4999);
			if (r < 2)
				send_item(CMD_START, 1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
					DATA_W'($urandom_range(255)));
			else if (r < 200)
				send_side_command();
			else
				send_item(CMD_TICK, 1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
					DATA_W'($urandom_range(255)));
		end
	endtask

	task automatic send_frame();
		int count;
		count = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : STORE_DEPTH;
		for (int i = 0; i < count; i++)
			send_item(CMD_WRITE_TX, 1'($urandom_range(1)),
				(count == STORE_DEPTH) ? ADDR_W'(i) : ADDR_W'($urandom_range(7)),
				DATA_W'($urandom_range(255)));
		send_item(CMD_START, 1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
			DATA_W'($urandom_range(255)));
		finish_transmit();
	endtask

	// A bad period either falls outside every window or is a header in mid-frame.
	task automatic receive_frame(int preamble, bit broken);
		int bad_at;
		int r;
		bad_at = broken ? $urandom_range(0, 8 * BYTES_PER_FRAME) : -1;
		repeat (preamble) send_tick(1'b1);
		send_symbol($urandom_range(HEADER_PERIOD_MIN, HEADER_PERIOD_MAX));
		for (int i = 0; i < 8 * BYTES_PER_FRAME; i++) begin
			if (i == bad_at) begin
				r = $urandom_range(99);
				if (r < 20)
					send_symbol(HEADER_PERIOD_MIN);
				else if (r < 60)
					send_symbol($urandom_range(2, ZERO_PERIOD_MIN - 1));
				else
					send_symbol($urandom_range(HEADER_PERIOD_MAX + 1, 60));
				break;
			end
			if ($urandom_range(1))
				send_symbol($urandom_range(ONE_PERIOD_MIN, ONE_PERIOD_MAX - 1));
			else
				send_symbol($urandom_range(ZERO_PERIOD_MIN, ZERO_PERIOD_MAX));
		end
		send_tick(1'b0);
		repeat ($urandom_range(1, 4)) send_tick(1'b1);
		for (int i = 0; i < STORE_DEPTH; i++)
			send_item(CMD_READ_RX, 1'($urandom_range(1)), ADDR_W'(i),
				DATA_W'($urandom_range(255)));
		if ($urandom_range(1))
			send_item(CMD_CLEAR_DONE, 1'($urandom_range(1)), ADDR_W'($urandom_range(7)),
				DATA_W'($urandom_range(255)));
	endtask

	task automatic send_noise(int count);
		int r;
		logic ln;
		ln = 1'($urandom_range(1));
		repeat (count) begin
			r = $urandom_range(99);
			if ($urandom_range(1))
				ln = 1'($urandom_range(1));
			if (r < 70)
				send_item(CMD_TICK, ln, ADDR_W'($urandom_range(7)),
					DATA_W'($urandom_range(255)));
			else if (r < 95)
				send_side_command();
			else
				send_item(CMD_START, ln, ADDR_W'($urandom_range(7)),
					DATA_W'($urandom_range(255)));
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		bit held;
		bit quiet;
		held = 1'b0;
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			quiet = result_count >= TAKE_QUIET_FROM && result_count < TAKE_QUIET_TO;
			if (!held && result_count >= HOLD_AT_RESULT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(99) < 6) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			seen = '{line_out, tx_busy, rx_done, rx_data};
			if (expected_status.size() == 0) begin
				log_failure("result transfer with nothing expected");
			end else begin
				wanted = expected_status.pop_front();
				if (seen !== wanted)
					log_failure($sformatf(
						"result %0d exp/act line %b/%b busy %b/%b done %b/%b data %h/%h",
						result_count, wanted.line_out, seen.line_out, wanted.tx_busy,
						seen.tx_busy, wanted.rx_done, seen.rx_done, wanted.rx_data,
						seen.rx_data));
			end
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("pulse_width_link_transceiver_tb failed");
		$finish;
	end

	initial begin
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TICK;
		line_in = 1'b0;
		index = '0;
		value = '0;
		item_count = 0;
		result_count = 0;
		fail_count = 0;
		clear_link_state();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_ROWS; i++)
			send_item(opening_rows[i].cmd, opening_rows[i].line, opening_rows[i].idx,
				opening_rows[i].val, opening_rows[i].typed, opening_rows[i].status);

		// The opening rows leave a frame on the wire; the long preamble saturates the timer.
		finish_transmit();
		receive_frame(PERIOD_CEILING + 15, 1'b0);
		wait_for_results();

		while (item_count < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 40)
				receive_frame($urandom_range(3, 30), $urandom_range(99) < 40);
			else if (pick < 60)
				send_frame();
			else
				send_noise($urandom_range(10, 40));
			finish_transmit();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_status.size() != 0)
			log_failure("expected results left over at the end");
		if (fail_count == 0)
			$display("pulse_width_link_transceiver_tb passed");
		else
			$display("pulse_width_link_transceiver_tb failed");
		$finish;
	end

endmodule
